>>> rtl/edos_pkg.sv
// ----------------------------------------------------------------------------
// edos_pkg
// Shared widths, codes and controller/datapath interface types for the
// entity draw-order sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package edos_pkg;

  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned CLASS_W  = 10;
  localparam int unsigned CCNT_W   = 11;
  localparam int unsigned OVR_W    = 8;
  localparam int unsigned DEPTH_W  = 32;
  localparam int unsigned GRP_W    = 4;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned GROUPS   = 1 << GRP_W;
  localparam int unsigned PER_GROUP = 1 << IDX_W;
  localparam int unsigned ENTRY_W  = SLOT_W + DEPTH_W;
  localparam int unsigned ADDR_W   = GRP_W + IDX_W;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_EMIT  = 2'd2;

  localparam logic [OVR_W-1:0]  NO_OVERRIDE   = 8'hFF;
  localparam logic [CCNT_W-1:0] CLASS_CNT_RST = 11'd1;

  typedef struct packed {
    logic clr_counts;
    logic ld_latch;
    logic em_latch;
    logic em_empty;
    logic ins_rd;
    logic ins_shift;
    logic ins_final;
    logic em_rd;
  } edos_cmd_t;

  typedef struct packed {
    logic load_ok;
    logic grp_nonzero;
    logic j_zero;
    logic greater;
    logic em_last;
  } edos_sts_t;

endpackage

`default_nettype wire

>>> rtl/edos_ctrl.sv
// ----------------------------------------------------------------------------
// edos_ctrl
// Sequencer for start, ordered insertion and group emission.
// ----------------------------------------------------------------------------
`default_nettype none

module edos_ctrl
  import edos_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] func_i,
  input  wire edos_sts_t  sts_i,
  output edos_cmd_t       cmd_o,
  output logic            busy_o
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_INS_CHK = 2'd1;
  localparam logic [1:0] ST_INS_CMP = 2'd2;
  localparam logic [1:0] ST_EMIT    = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_START: cmd_o.clr_counts = 1'b1;
            FUNC_LOAD: begin
              if (sts_i.load_ok) begin
                cmd_o.ld_latch = 1'b1;
                state_d        = ST_INS_CHK;
              end
            end
            FUNC_EMIT: begin
              if (sts_i.grp_nonzero) begin
                cmd_o.em_latch = 1'b1;
                state_d        = ST_EMIT;
              end else begin
                cmd_o.em_empty = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INS_CHK: begin
        if (sts_i.j_zero) begin
          cmd_o.ins_final = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.greater) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = ST_INS_CHK;
        end else begin
          cmd_o.ins_final = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_EMIT: begin
        cmd_o.em_rd = 1'b1;
        if (sts_i.em_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/edos_dp.sv
// ----------------------------------------------------------------------------
// edos_dp
// Bucket memory, group counts, load filter, depth compare and result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module edos_dp
  import edos_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire edos_cmd_t           cmd_i,
  output edos_sts_t                sts_o,
  input  wire logic [SLOT_W-1:0]   slot_i,
  input  wire logic [CLASS_W-1:0]  ent_class_i,
  input  wire logic                never_active_i,
  input  wire logic                has_draw_i,
  input  wire logic [OVR_W-1:0]    group_override_i,
  input  wire logic [GRP_W-1:0]    class_group_i,
  input  wire logic signed [DEPTH_W-1:0] depth_i,
  input  wire logic [GRP_W-1:0]    group_select_i,
  input  wire logic                class_count_we_i,
  input  wire logic [CCNT_W-1:0]   class_count_i,
  output logic [SLOT_W-1:0]        slot_out_o,
  output logic                     group_empty_o,
  output logic                     last_o,
  output logic                     result_valid_o
);

  logic [ENTRY_W-1:0] mem [MEM_DEPTH];

  logic [CCNT_W-1:0]  class_cnt_q;
  logic [CNT_W-1:0]   counts_q [GROUPS];
  logic [GRP_W-1:0]   grp_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [IDX_W-1:0]   j_q;
  logic [IDX_W-1:0]   i_q;
  logic [ENTRY_W-1:0] rd_q;
  logic               out_valid_q;
  logic               out_last_q;
  logic               out_empty_q;

  logic [OVR_W-1:0]   grp_raw;
  logic [GRP_W-1:0]   grp_in;
  logic               mem_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               mem_re;
  logic [ADDR_W-1:0]  rd_addr;
  logic [IDX_W-1:0]   j_dec;
  logic [CNT_W-1:0]   i_inc;

  // group choice with clamp to the last group
  assign grp_raw = (group_override_i != NO_OVERRIDE) ? group_override_i
                                                     : {{(OVR_W-GRP_W){1'b0}}, class_group_i};
  assign grp_in  = (grp_raw >= OVR_W'(GROUPS)) ? GRP_W'(GROUPS - 1) : grp_raw[GRP_W-1:0];

  assign sts_o.load_ok = (ent_class_i != '0) && !never_active_i && has_draw_i &&
                         ({1'b0, ent_class_i} < class_cnt_q) &&
                         (counts_q[grp_in] != CNT_W'(PER_GROUP));
  assign sts_o.grp_nonzero = (counts_q[group_select_i] != '0);
  assign sts_o.j_zero      = (j_q == '0);
  assign sts_o.greater     = ($signed(rd_q[DEPTH_W-1:0]) > $signed(depth_q));
  assign i_inc             = {1'b0, i_q} + CNT_W'(1);
  assign sts_o.em_last     = (i_inc == counts_q[grp_q]);

  assign j_dec   = j_q - IDX_W'(1);
  assign mem_we  = cmd_i.ins_shift || cmd_i.ins_final;
  assign wr_addr = {grp_q, j_q};
  assign wr_data = cmd_i.ins_shift ? rd_q : {slot_q, depth_q};
  assign mem_re  = cmd_i.ins_rd || cmd_i.em_rd;
  assign rd_addr = cmd_i.ins_rd ? {grp_q, j_dec} : {grp_q, i_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  // latched item fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_latch) begin
      grp_q   <= grp_in;
      slot_q  <= slot_i;
      depth_q <= depth_i;
      j_q     <= counts_q[grp_in][IDX_W-1:0];
    end else if (cmd_i.ins_shift) begin
      j_q <= j_dec;
    end
    if (cmd_i.em_latch) begin
      grp_q <= group_select_i;
      i_q   <= '0;
    end else if (cmd_i.em_rd) begin
      i_q <= i_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_cnt_q <= CLASS_CNT_RST;
      for (int g = 0; g < GROUPS; g++) begin
        counts_q[g] <= '0;
      end
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else begin
      if (class_count_we_i) begin
        class_cnt_q <= class_count_i;
      end
      if (cmd_i.clr_counts) begin
        for (int g = 0; g < GROUPS; g++) begin
          counts_q[g] <= '0;
        end
      end else if (cmd_i.ins_final) begin
        counts_q[grp_q] <= counts_q[grp_q] + CNT_W'(1);
      end
      out_valid_q <= cmd_i.em_rd || cmd_i.em_empty;
      out_last_q  <= cmd_i.em_empty || (cmd_i.em_rd && sts_o.em_last);
      out_empty_q <= cmd_i.em_empty;
    end
  end

  assign slot_out_o     = out_empty_q ? '0 : rd_q[ENTRY_W-1:DEPTH_W];
  assign group_empty_o  = out_empty_q;
  assign last_o         = out_last_q;
  assign result_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/entity_draw_order_sorter_top.sv
// ----------------------------------------------------------------------------
// entity_draw_order_sorter_top
// Per-group draw lists kept in ascending depth order, emitted on request.
//
//   channel   handshake                    payload
//   item      start_i / busy_o             func_i .. group_select_i
//   config    class_count_we_i             class_count_i
//   result    result_valid_o (one cycle)   slot_out_o, group_empty_o, last_o
//
// start leaves the block idle; a load that passes the filter stays busy
// while the read/compare/write loop over the bucket memory moves each deeper
// entry up one place, until it meets an entry that is not deeper or the
// list start, then writes the new entry; a skipped load is not busy. An emit
// of n entries reads one entry a cycle and is busy until its last read,
// each result following in the cycle after its read; an empty group gives
// its single word the cycle after acceptance. Reset clears counts and state;
// the bucket memory is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module entity_draw_order_sorter_top
  import edos_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [1:0]                func_i,
  input  wire logic [SLOT_W-1:0]         slot_i,
  input  wire logic [CLASS_W-1:0]        ent_class_i,
  input  wire logic                      never_active_i,
  input  wire logic                      has_draw_i,
  input  wire logic [OVR_W-1:0]          group_override_i,
  input  wire logic [GRP_W-1:0]          class_group_i,
  input  wire logic signed [DEPTH_W-1:0] depth_i,
  input  wire logic [GRP_W-1:0]          group_select_i,
  input  wire logic                      class_count_we_i,
  input  wire logic [CCNT_W-1:0]         class_count_i,
  output logic                           result_valid_o,
  output logic [SLOT_W-1:0]              slot_out_o,
  output logic                           group_empty_o,
  output logic                           last_o
);

  edos_cmd_t cmd;
  edos_sts_t sts;

  edos_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  edos_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .slot_i          (slot_i),
    .ent_class_i     (ent_class_i),
    .never_active_i  (never_active_i),
    .has_draw_i      (has_draw_i),
    .group_override_i(group_override_i),
    .class_group_i   (class_group_i),
    .depth_i         (depth_i),
    .group_select_i  (group_select_i),
    .class_count_we_i(class_count_we_i),
    .class_count_i   (class_count_i),
    .slot_out_o      (slot_out_o),
    .group_empty_o   (group_empty_o),
    .last_o          (last_o),
    .result_valid_o  (result_valid_o)
  );

endmodule

`default_nettype wire
